// File: rtl/lbl_pkg.sv
// Shared types and constants of the LED blink logic.
package lbl_pkg;

    // Default sizes of the block.
    localparam int LED_COUNT_DEF    = 24;
    localparam int BUTTON_COUNT_DEF = 64;
    localparam int TIMER_COUNT_DEF  = 4;

    // Fixed widths of the stream and configuration fields.
    localparam int TMR_MAX    = 4;
    localparam int LED_MAX    = 64;
    localparam int OUT_W      = 24;
    localparam int IN_DATA_W  = 120;
    localparam int CFG_IDX_W  = 2;
    localparam int PERIOD_W   = 16;
    localparam int TIME_W     = 32;
    localparam int BTN_W      = 64;
    localparam int IDX_IN_W   = 5;
    localparam int BTN_IDX_W  = 6;
    localparam int TSEL_W     = 2;

    // Request kinds carried in tuser.
    localparam logic REQ_TABLE_WRITE = 1'b0;
    localparam logic REQ_TICK        = 1'b1;

    // One LED table entry as stored in the table memory.
    typedef struct packed {
        logic                 enabled;
        logic [BTN_IDX_W-1:0] button;
        logic                 src_inv;
        logic                 inv_mode;
        logic                 timer_en;
        logic [TSEL_W-1:0]    timer_sel;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Control from the table walker to the shared timers.
    typedef struct packed {
        logic              calc;
        logic              commit;
        logic [TMR_MAX-1:0] used;
        logic [TIME_W-1:0] now;
    } t_tmr_ctl;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FIRE = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

// File: rtl/lbl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lbl_timers.sv
// Shared blink timers: periods, last fire times and the fire decision.
module lbl_timers
    import lbl_pkg::*;
#(
    parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PERIOD_W-1:0]  i_cfg_data,
    input  t_tmr_ctl             i_ctl,
    output logic [TMR_MAX-1:0]   o_fires
);

    logic [PERIOD_W-1:0] r_period [TIMER_COUNT];
    logic [TIME_W-1:0]   r_last   [TIMER_COUNT];
    logic [TMR_MAX-1:0]  r_fires;
    logic [TMR_MAX-1:0]  n_fires;

    // A timer fires when the wrapped difference is non-negative and above the period.
    always_comb begin
        logic [TIME_W-1:0] diff;
        n_fires = '0;
        for (int t = 0; t < TIMER_COUNT; t++) begin
            diff       = i_ctl.now - r_last[t];
            n_fires[t] = !diff[TIME_W-1] && (diff > TIME_W'(r_period[t]));
        end
    end

    // Period registers, restart times and the latched fire flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fires <= '0;
            for (int t = 0; t < TIMER_COUNT; t++) begin
                r_period[t] <= '0;
                r_last[t]   <= '0;
            end
        end else begin
            if (i_ctl.calc) begin
                r_fires <= n_fires;
            end
            for (int t = 0; t < TIMER_COUNT; t++) begin
                if (i_cfg_we && (32'(i_cfg_idx) == t)) begin
                    r_period[t] <= i_cfg_data;
                end
                if (i_ctl.commit && i_ctl.used[t] && r_fires[t]) begin
                    r_last[t] <= i_ctl.now;
                end
            end
        end
    end

    assign o_fires = r_fires;

endmodule

// File: rtl/lbl_ctrl.sv
// Table memory, valid bits, LED bits and the sequencer that walks the table on a tick.
module lbl_ctrl
    import lbl_pkg::*;
#(
    parameter int LED_COUNT    = LED_COUNT_DEF,
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEF,
    parameter int TIMER_COUNT  = TIMER_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_tick,
    input  logic [IDX_IN_W-1:0]  i_led_index,
    input  t_entry               i_entry,
    input  logic [TIME_W-1:0]    i_time,
    input  logic [BTN_W-1:0]     i_buttons,
    input  logic                 i_out_free,
    output logic                 o_done,
    output logic [LED_COUNT-1:0] o_led_bits,
    output t_tmr_ctl             o_tmr,
    input  logic [TMR_MAX-1:0]   i_fires
);

    localparam int LI_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int CNT_W = $clog2(LED_COUNT + 1);

    t_state               r_state, n_state;
    logic [LED_COUNT-1:0] r_valid;
    logic [LED_COUNT-1:0] r_led_bits, n_led_bits;
    logic [CNT_W-1:0]     r_cnt;
    logic [LI_W-1:0]      r_pidx;
    logic [TMR_MAX-1:0]   r_used, n_used;
    logic                 r_tick;
    logic [TIME_W-1:0]    r_time;
    logic [BTN_W-1:0]     r_buttons;

    logic                 accept;
    logic                 wr_en;
    logic                 rd_en;
    logic [LI_W-1:0]      rd_addr;
    logic [ENTRY_W-1:0]   rd_data;
    t_entry               ent;
    logic                 last_entry;

    assign o_ready = (r_state == S_IDLE) && i_out_free;
    assign accept  = i_valid && o_ready;
    // Writes beyond the table are dropped.
    assign wr_en   = accept && !i_tick && (32'(i_led_index) < LED_COUNT);

    // Reads: entry zero in the fire step, then one entry ahead of the one processed.
    assign rd_en   = (r_state == S_FIRE) ||
                     ((r_state == S_WALK) && (32'(r_cnt) < LED_COUNT));
    assign rd_addr = (r_state == S_FIRE) ? '0 : r_cnt[LI_W-1:0];

    // The table is written only at accept, the walk reads it later, so accesses never overlap.
    lbl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LED_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (LI_W'(i_led_index)),
        .i_wdata (i_entry),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign ent        = t_entry'(rd_data);
    assign last_entry = (r_pidx == LI_W'(LED_COUNT - 1));

    // Update of one LED bit from the entry read in the previous cycle.
    always_comb begin
        logic but;
        logic on_cond;
        logic blink;
        logic fire_sel;
        n_led_bits = r_led_bits;
        n_used     = r_used;
        but        = 1'b0;
        fire_sel   = 1'b0;
        if (32'(ent.button) < BUTTON_COUNT) begin
            but = r_buttons[ent.button];
        end
        but     = but ^ ent.src_inv;
        on_cond = but ^ ent.inv_mode;
        blink   = on_cond && ent.timer_en && (32'(ent.timer_sel) < TIMER_COUNT);
        for (int t = 0; t < TMR_MAX; t++) begin
            if (32'(ent.timer_sel) == t) begin
                fire_sel = i_fires[t];
            end
        end
        if ((r_state == S_WALK) && r_valid[r_pidx] && ent.enabled) begin
            if (blink) begin
                n_used[ent.timer_sel] = 1'b1;
                n_led_bits[r_pidx]    = r_led_bits[r_pidx] ^ fire_sel;
            end else begin
                n_led_bits[r_pidx]    = on_cond;
            end
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_tick ? S_FIRE : S_DONE;
                end
            end
            S_FIRE: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (last_entry) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_led_bits <= '0;
            r_cnt      <= '0;
            r_pidx     <= '0;
            r_used     <= '0;
            r_tick     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_led_bits <= n_led_bits;
            if (wr_en) begin
                r_valid[LI_W'(i_led_index)] <= 1'b1;
            end
            if (accept) begin
                r_tick <= i_tick;
            end
            if (r_state == S_FIRE) begin
                r_cnt  <= CNT_W'(1);
                r_pidx <= '0;
                r_used <= '0;
            end else if (r_state == S_WALK) begin
                r_cnt  <= r_cnt + CNT_W'(1);
                r_pidx <= r_cnt[LI_W-1:0];
                r_used <= n_used;
            end
        end
    end

    // Tick payload.
    always_ff @(posedge i_clk) begin
        if (accept && i_tick) begin
            r_time    <= i_time;
            r_buttons <= i_buttons;
        end
    end

    assign o_done     = (r_state == S_DONE);
    assign o_led_bits = r_led_bits;

    always_comb begin
        o_tmr        = '0;
        o_tmr.calc   = (r_state == S_FIRE);
        o_tmr.commit = (r_state == S_DONE) && r_tick;
        o_tmr.used   = r_used;
        o_tmr.now    = r_time;
    end

    // A tick always starts with the timer evaluation.
    a_tick_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_tick) |=> (r_state == S_FIRE))
        else $error("tick did not enter the fire step");

    // Every entry processed in the walk was read in the cycle before.
    a_walk_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> $past(rd_en))
        else $error("walk consumed read data that was never requested");

    // LED bits change only while the table is walked.
    a_bits_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_WALK) |=> $stable(r_led_bits))
        else $error("LED bits changed outside the walk");

    // One result per item.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

endmodule

// File: rtl/led_blink_logic_top.sv
// Top level of the LED blink logic: stream ports, configuration port and result register.
//
// Each input item gives one result item holding the LED states after it. A table write
// stores one entry, if its index lies within the table, and returns its result from the
// done step. A tick has a fire step that evaluates the four shared timers, then the LED
// table is walked at one entry per cycle through the single read port of the table
// memory, and a done step restarts the fired timers and loads the result. One item is
// in work at a time; the next is taken once the result register has been emptied. The
// table resets to all disabled through per-entry valid bits, so no clearing pass is
// needed. The user must write blink periods only while idle; the block does not check.
module led_blink_logic_top
    import lbl_pkg::*;
#(
    parameter int LED_COUNT    = LED_COUNT_DEF,
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEF,
    parameter int TIMER_COUNT  = TIMER_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // led_index[4:0], source_enabled[5], source_button[11:6], source_inverted[12],
    // inverted_mode[13], timer_enabled[14], timer_select[16:15], time_ms[48:17],
    // button_states[112:49], zero fill[119:113]
    input  logic [IN_DATA_W-1:0] i_s_tdata,
    // req_type[0]
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // led_states[23:0]
    output logic [OUT_W-1:0]     o_m_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PERIOD_W-1:0]  i_cfg_data
);

    t_entry               in_entry;
    t_tmr_ctl             tmr_ctl;
    logic [TMR_MAX-1:0]   fires;
    logic                 done;
    logic [LED_COUNT-1:0] led_bits;
    logic [LED_MAX-1:0]   led_wide;
    logic                 r_m_valid;
    logic [OUT_W-1:0]     r_m_data;

    // Unpack the table entry fields from the item.
    always_comb begin
        in_entry.enabled   = i_s_tdata[5];
        in_entry.button    = i_s_tdata[11:6];
        in_entry.src_inv   = i_s_tdata[12];
        in_entry.inv_mode  = i_s_tdata[13];
        in_entry.timer_en  = i_s_tdata[14];
        in_entry.timer_sel = i_s_tdata[16:15];
    end

    lbl_ctrl #(
        .LED_COUNT    (LED_COUNT),
        .BUTTON_COUNT (BUTTON_COUNT),
        .TIMER_COUNT  (TIMER_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_tick      (i_s_tuser == REQ_TICK),
        .i_led_index (i_s_tdata[4:0]),
        .i_entry     (in_entry),
        .i_time      (i_s_tdata[48:17]),
        .i_buttons   (i_s_tdata[112:49]),
        .i_out_free  (!r_m_valid),
        .o_done      (done),
        .o_led_bits  (led_bits),
        .o_tmr       (tmr_ctl),
        .i_fires     (fires)
    );

    lbl_timers #(
        .TIMER_COUNT (TIMER_COUNT)
    ) u_timers (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (tmr_ctl),
        .o_fires    (fires)
    );

    // Only the low LEDs are shown in the result.
    assign led_wide = LED_MAX'(led_bits);

    // Result register toward the master side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (done) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_m_data <= led_wide[OUT_W-1:0];
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

// File: bench/led_blink_logic_top_tb.sv
// Self-checking stream testbench of the LED blink logic with a built-in LED state predictor.
`timescale 1ns / 1ps

module led_blink_logic_top_tb;
    import lbl_pkg::*;

    localparam int LEDS       = LED_COUNT_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int END_WAIT   = 40;
    localparam int MAX_SHOWN  = 10;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD_0 = 2'd0,
        REG_PERIOD_1 = 2'd1,
        REG_PERIOD_2 = 2'd2,
        REG_PERIOD_3 = 2'd3
    } t_reg;

    // Fields of tdata, highest first so that led_index lands in the low bits.
    typedef struct packed {
        logic [6:0]           fill;
        logic [BTN_W-1:0]     buttons;
        logic [TIME_W-1:0]    now;
        logic [TSEL_W-1:0]    tsel;
        logic                 tmr_en;
        logic                 inv_mode;
        logic                 src_inv;
        logic [BTN_IDX_W-1:0] button;
        logic                 src_en;
        logic [IDX_IN_W-1:0]  idx;
    } t_req_data;

    typedef struct packed {
        logic      kind;
        t_req_data data;
    } t_req;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [IN_DATA_W-1:0] i_s_tdata  = '0;
    logic                 i_s_tuser  = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [OUT_W-1:0]     o_m_tdata;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [PERIOD_W-1:0]  i_cfg_data = '0;

    led_blink_logic_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: LED table, LED bits, timer restarts and blink periods.
    logic                 tbl_en       [LEDS];
    logic [BTN_IDX_W-1:0] tbl_btn      [LEDS];
    logic                 tbl_src_inv  [LEDS];
    logic                 tbl_inv_mode [LEDS];
    logic                 tbl_tmr_en   [LEDS];
    logic [TSEL_W-1:0]    tbl_tsel     [LEDS];
    logic [OUT_W-1:0]     lit_leds;
    logic [TIME_W-1:0]    last_fire    [TMR_MAX];
    logic [PERIOD_W-1:0]  blink_half   [TMR_MAX];

    t_req             pending_reqs [$];
    logic [OUT_W-1:0] led_states_due [$];
    t_req             cur_req;
    int               mismatch_count = 0;
    int               gap_left = 0;
    int               stall_left = 0;
    int               quiet_s = 0;
    int               quiet_m = 0;
    int               idle_cycles = 0;

    // Stimulus history: running millisecond time and button vector.
    logic [TIME_W-1:0] clock_ms = '0;
    logic [BTN_W-1:0]  btn_vec  = '0;

    initial begin
        for (int i = 0; i < LEDS; i++) begin
            tbl_en[i]       = 1'b0;
            tbl_btn[i]      = '0;
            tbl_src_inv[i]  = 1'b0;
            tbl_inv_mode[i] = 1'b0;
            tbl_tmr_en[i]   = 1'b0;
            tbl_tsel[i]     = '0;
        end
        for (int t = 0; t < TMR_MAX; t++) begin
            last_fire[t]  = '0;
            blink_half[t] = '0;
        end
        lit_leds = '0;
    end

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one item to the predictor state and returns the LED states after it.
    function automatic logic [OUT_W-1:0] next_led_states(input t_req r);
        logic [TIME_W-1:0] diff;
        logic [TMR_MAX-1:0] fires;
        logic [TMR_MAX-1:0] used;
        logic btn;
        logic on;
        fires = '0;
        used  = '0;
        if (r.kind == REQ_TABLE_WRITE) begin
            if (r.data.idx < LEDS) begin
                tbl_en[r.data.idx]       = r.data.src_en;
                tbl_btn[r.data.idx]      = r.data.button;
                tbl_src_inv[r.data.idx]  = r.data.src_inv;
                tbl_inv_mode[r.data.idx] = r.data.inv_mode;
                tbl_tmr_en[r.data.idx]   = r.data.tmr_en;
                tbl_tsel[r.data.idx]     = r.data.tsel;
            end
        end else begin
            // A timer fires when the wrapped elapsed time is positive and above its period.
            for (int t = 0; t < TMR_MAX; t++) begin
                diff = r.data.now - last_fire[t];
                fires[t] = !diff[TIME_W-1] && (diff > {16'd0, blink_half[t]});
            end
            for (int i = 0; i < LEDS; i++) begin
                if (tbl_en[i]) begin
                    btn = r.data.buttons[tbl_btn[i]] ^ tbl_src_inv[i];
                    on  = tbl_inv_mode[i] ? !btn : btn;
                    if (on && tbl_tmr_en[i]) begin
                        used[tbl_tsel[i]] = 1'b1;
                        if (fires[tbl_tsel[i]])
                            lit_leds[i] = ~lit_leds[i];
                    end else begin
                        lit_leds[i] = on;
                    end
                end
            end
            for (int t = 0; t < TMR_MAX; t++)
                if (used[t] && fires[t])
                    last_fire[t] = r.data.now;
        end
        return lit_leds;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // All fields random, fill bits zero.
    function automatic t_req_data random_fields();
        t_req_data d;
        d.fill     = '0;
        d.buttons  = {$urandom, $urandom};
        d.now      = $urandom;
        d.tsel     = TSEL_W'($urandom);
        d.tmr_en   = 1'($urandom);
        d.inv_mode = 1'($urandom);
        d.src_inv  = 1'($urandom);
        d.button   = BTN_IDX_W'($urandom);
        d.src_en   = 1'($urandom);
        d.idx      = IDX_IN_W'($urandom);
        return d;
    endfunction

    function automatic t_req table_write(input logic [IDX_IN_W-1:0] idx, input logic en,
                                         input logic [BTN_IDX_W-1:0] button, input logic sinv,
                                         input logic imode, input logic ten,
                                         input logic [TSEL_W-1:0] tsel);
        t_req r;
        r.kind          = REQ_TABLE_WRITE;
        r.data          = random_fields();
        r.data.idx      = idx;
        r.data.src_en   = en;
        r.data.button   = button;
        r.data.src_inv  = sinv;
        r.data.inv_mode = imode;
        r.data.tmr_en   = ten;
        r.data.tsel     = tsel;
        return r;
    endfunction

    function automatic t_req tick(input logic [TIME_W-1:0] now, input logic [BTN_W-1:0] btns);
        t_req r;
        r.kind         = REQ_TICK;
        r.data         = random_fields();
        r.data.now     = now;
        r.data.buttons = btns;
        return r;
    endfunction

    // A table entry for the given LED index, mostly enabled and mostly blinking.
    function automatic t_req random_entry(input logic [IDX_IN_W-1:0] idx);
        return table_write(idx, $urandom_range(0, 9) != 0, BTN_IDX_W'($urandom),
                           1'($urandom), 1'($urandom),
                           $urandom_range(0, 9) < 7, TSEL_W'($urandom));
    endfunction

    // A tick that moves time and buttons on from the previous one.
    function automatic t_req next_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            clock_ms = clock_ms + $urandom_range(0, 25);
        else if (r < 85)
            clock_ms = clock_ms + $urandom_range(0, 300);
        else if (r < 93)
            clock_ms = clock_ms + $urandom_range(0, 70000);
        else if (r < 97)
            clock_ms = clock_ms + $urandom;
        r = $urandom_range(0, 99);
        if (r < 60)
            btn_vec[BTN_IDX_W'($urandom_range(0, BTN_W-1))] ^= 1'b1;
        else if (r < 90 && r >= 80)
            btn_vec = {$urandom, $urandom};
        else if (r >= 90)
            btn_vec = {BTN_W{r[0]}};
        return tick(clock_ms, btn_vec);
    endfunction

    task automatic flag_result(input string what, input logic [OUT_W-1:0] exp_v,
                               input logic [OUT_W-1:0] act_v);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("%0t: %s: led_states expected %06h, got %06h", $realtime, what, exp_v,
                     act_v);
    endtask

    // Driver: feeds queued items onto the input stream and predicts each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                led_states_due.push_back(next_led_states(cur_req));
                gap_left = (quiet_s > 0) ? 0 : pick_gap();
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    i_s_tuser  <= cur_req.kind;
                    i_s_tdata  <= cur_req.data;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            if (quiet_s > 0)
                quiet_s--;
            else if ($urandom_range(0, 199) == 0)
                quiet_s = $urandom_range(30, 120);
        end
    end

    // Monitor: checks every accepted result item and stalls the output at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (led_states_due.size() == 0)
                    flag_result("unexpected item", '0, o_m_tdata);
                else if (o_m_tdata !== led_states_due[0])
                    flag_result("mismatch", led_states_due[0], o_m_tdata);
                if (led_states_due.size() > 0)
                    void'(led_states_due.pop_front());
                stall_left = (quiet_m > 0) ? 0 : pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
            if (quiet_m > 0)
                quiet_m--;
            else if ($urandom_range(0, 199) == 0)
                quiet_m = $urandom_range(30, 120);
        end
    end

    // Watchdog: ends the run when neither side moves an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic write_period(input t_reg which, input logic [PERIOD_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= which;
        i_cfg_data <= val;
        blink_half[which] = val;
    endtask

    task automatic set_periods(input logic [PERIOD_W-1:0] p0, p1, p2, p3);
        write_period(REG_PERIOD_0, p0);
        write_period(REG_PERIOD_1, p1);
        write_period(REG_PERIOD_2, p2);
        write_period(REG_PERIOD_3, p3);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every queued item is taken and every expected result has come.
    task automatic settle();
        while (pending_reqs.size() > 0 || i_s_tvalid || led_states_due.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // A full table load, then mostly ticks with some rewrites; drains once midway.
    task automatic run_random_phase(input int count);
        for (int i = 0; i < LEDS; i++)
            pending_reqs.push_back(random_entry(IDX_IN_W'(i)));
        for (int n = 0; n < count; n++) begin
            if (n == count / 2)
                settle();
            if ($urandom_range(0, 99) < 20)
                pending_reqs.push_back(random_entry(IDX_IN_W'(($urandom_range(0, 9) == 0) ?
                                                    $urandom_range(LEDS, 31) :
                                                    $urandom_range(0, LEDS-1))));
            else
                pending_reqs.push_back(next_tick());
        end
    endtask

    // Main sequence.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with all periods still at their reset value of zero.
        pending_reqs.push_back(tick(32'd0, '0));
        pending_reqs.push_back(table_write(5'd0, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 2'd0));
        pending_reqs.push_back(table_write(5'd23, 1'b1, 6'd63, 1'b1, 1'b1, 1'b1, 2'd3));
        pending_reqs.push_back(table_write(5'd24, 1'b1, 6'd1, 1'b0, 1'b0, 1'b0, 2'd0));
        pending_reqs.push_back(table_write(5'd31, 1'b1, 6'd2, 1'b1, 1'b0, 1'b1, 2'd1));
        pending_reqs.push_back(table_write(5'd5, 1'b1, 6'd5, 1'b0, 1'b0, 1'b1, 2'd0));
        pending_reqs.push_back(table_write(5'd6, 1'b1, 6'd6, 1'b0, 1'b1, 1'b1, 2'd1));
        pending_reqs.push_back(table_write(5'd7, 1'b1, 6'd7, 1'b1, 1'b0, 1'b1, 2'd2));
        pending_reqs.push_back(table_write(5'd8, 1'b0, 6'd8, 1'b0, 1'b0, 1'b0, 2'd0));
        pending_reqs.push_back(tick(32'd0, '1));
        pending_reqs.push_back(tick(32'd1, '1));
        pending_reqs.push_back(tick(32'd2, '0));
        pending_reqs.push_back(tick(32'h7FFF_FFFF, '1));
        pending_reqs.push_back(tick(32'hFFFF_FFFF, '1));
        pending_reqs.push_back(tick(32'h8000_0001, '1));
        pending_reqs.push_back(tick(32'd0, {$urandom, $urandom}));
        pending_reqs.push_back(table_write(5'd8, 1'b1, 6'd8, 1'b0, 1'b1, 1'b1, 2'd3));
        pending_reqs.push_back(table_write(5'd0, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 2'd0));
        pending_reqs.push_back(tick(32'd5, '1));
        pending_reqs.push_back(tick(32'd9, '0));
        pending_reqs.push_back(tick(32'd12, {$urandom, $urandom}));
        clock_ms = 32'd12;
        settle();

        // Random phases across several period settings, extremes among them.
        set_periods(16'd0, 16'd1, 16'd7, 16'd20);
        run_random_phase(66);
        settle();
        set_periods(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random_phase(66);
        settle();
        set_periods(PERIOD_W'($urandom_range(0, 40)), PERIOD_W'($urandom_range(0, 40)),
                    PERIOD_W'($urandom_range(0, 40)), PERIOD_W'($urandom_range(0, 40)));
        run_random_phase(66);
        settle();
        set_periods(PERIOD_W'($urandom), PERIOD_W'($urandom), PERIOD_W'($urandom),
                    PERIOD_W'($urandom));
        run_random_phase(66);
        settle();
        set_periods(16'd2, 16'd3, 16'd5, 16'd11);
        run_random_phase(66);
        settle();

        repeat (END_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && led_states_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
